FILE: rtl/core/upitl_pkg.sv
// ----------------------------------------------------------------------------
// upitl_pkg
// Shared constants, types and helpers for the point-in-triangle locator.
// ----------------------------------------------------------------------------
package upitl_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_FACES    = 1024;
  localparam int VA_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int FA_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int FC_W = $clog2(MAX_FACES + 1);

  localparam int COORD_W   = 24;
  localparam int IDX_W     = 10;
  localparam int DIFF_W    = 25;
  localparam int PROD_W    = 50;
  localparam int SUM_W     = 51;
  localparam int DET_MIN_W = 48;
  localparam int MARGIN_W  = 16;
  localparam int QUOT_W    = 25;
  localparam int EXT_W     = 26;
  localparam int CFG_W     = 48;

  localparam logic signed [EXT_W-1:0] ONE_Q16 = 26'sd65536;
  localparam logic signed [EXT_W-1:0] WMAX    = 26'sd8388607;
  localparam logic signed [EXT_W-1:0] WMIN    = -26'sd8388608;

  localparam logic [1:0] KIND_VTX  = 2'd0;
  localparam logic [1:0] KIND_FACE = 2'd1;
  localparam logic [1:0] KIND_QRY  = 2'd2;

  localparam logic REG_DET_MIN = 1'b0;
  localparam logic REG_MARGIN  = 1'b1;

  typedef enum logic [1:0] {
    OP_VTX,
    OP_FACE,
    OP_QRY
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   slot;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic [IDX_W-1:0]   ca;
    logic [IDX_W-1:0]   cb;
    logic [IDX_W-1:0]   cc;
    logic               last;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   index;
    logic [COORD_W-1:0] wa;
    logic [COORD_W-1:0] wb;
    logic [COORD_W-1:0] wc;
  } result_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_VRD,
    B_FWR,
    B_QRD,
    B_QBOX,
    B_QDIFF,
    B_QMUL,
    B_QDET,
    B_QDIVA,
    B_QDIVB,
    B_QCHK,
    B_QOUT
  } bstate_t;

  function automatic logic signed [EXT_W-1:0] sx26(input logic [COORD_W-1:0] x);
    sx26 = signed'({{(EXT_W-COORD_W){x[COORD_W-1]}}, x});
  endfunction

  function automatic logic signed [DIFF_W-1:0] sx25(input logic [COORD_W-1:0] x);
    sx25 = signed'({x[COORD_W-1], x});
  endfunction

  // quotient to signed Q8.16 weight, saturated
  function automatic logic [COORD_W-1:0] wsat(input logic [QUOT_W-1:0] q, input logic neg);
    logic [QUOT_W-1:0] mag;
    logic [QUOT_W-1:0] nmag;
    mag  = q[QUOT_W-1] ? 25'h1000000 : {1'b0, q[COORD_W-1:0]};
    nmag = ~mag + 25'd1;
    if (neg) begin
      wsat = (mag > 25'h0800000) ? 24'h800000 : nmag[COORD_W-1:0];
    end else begin
      wsat = (mag > 25'h07FFFFF) ? 24'h7FFFFF : mag[COORD_W-1:0];
    end
  endfunction

  function automatic logic [COORD_W-1:0] sat24(input logic signed [EXT_W-1:0] x);
    if (x > WMAX) begin
      sat24 = 24'h7FFFFF;
    end else if (x < WMIN) begin
      sat24 = 24'h800000;
    end else begin
      sat24 = x[COORD_W-1:0];
    end
  endfunction

  function automatic logic w_ok(input logic [COORD_W-1:0] w, input logic [MARGIN_W-1:0] m);
    logic signed [EXT_W-1:0] ws;
    logic signed [EXT_W-1:0] ms;
    ws   = sx26(w);
    ms   = signed'({{(EXT_W-MARGIN_W){1'b0}}, m});
    w_ok = (ws >= -ms) && (ws <= ONE_Q16 + ms);
  endfunction

endpackage

FILE: rtl/core/upitl_front.sv
// ----------------------------------------------------------------------------
// upitl_front
// Accepts items, decodes their kind and queues known ones for the back end.
// ----------------------------------------------------------------------------
module upitl_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        kind,
  input  logic [upitl_pkg::IDX_W-1:0]       slot,
  input  logic [upitl_pkg::COORD_W-1:0]     coord_u,
  input  logic [upitl_pkg::COORD_W-1:0]     coord_v,
  input  logic [upitl_pkg::IDX_W-1:0]       corner_a,
  input  logic [upitl_pkg::IDX_W-1:0]       corner_b,
  input  logic [upitl_pkg::IDX_W-1:0]       corner_c,
  input  logic                              last_face,
  output logic                              q_valid,
  output upitl_pkg::item_t                  q_item,
  input  logic                              q_pop
);

  upitl_pkg::item_t fifo [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       keep;
  logic       do_push;
  logic       do_pop;
  upitl_pkg::item_t in_item;

  always_comb begin
    in_item.op   = upitl_pkg::OP_VTX;
    keep         = 1'b1;
    case (kind)
      upitl_pkg::KIND_VTX:  in_item.op = upitl_pkg::OP_VTX;
      upitl_pkg::KIND_FACE: in_item.op = upitl_pkg::OP_FACE;
      upitl_pkg::KIND_QRY:  in_item.op = upitl_pkg::OP_QRY;
      default:              keep = 1'b0;
    endcase
    in_item.slot = slot;
    in_item.u    = coord_u;
    in_item.v    = coord_v;
    in_item.ca   = corner_a;
    in_item.cb   = corner_b;
    in_item.cc   = corner_c;
    in_item.last = last_face;
  end

  assign full    = (count == 3'd4);
  assign q_valid = (count != 3'd0);
  assign q_item  = fifo[rd_ptr];
  assign do_push = push && !full && keep;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'b0, do_push} - {2'b0, do_pop};
    end
  end

endmodule

FILE: rtl/core/upitl_div.sv
// ----------------------------------------------------------------------------
// upitl_div
// Restoring divider: floor(num * 2^16 / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module upitl_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [upitl_pkg::SUM_W-1:0]     num,
  input  logic [upitl_pkg::SUM_W-1:0]     den,
  output logic                            done,
  output logic [upitl_pkg::QUOT_W-1:0]    quot
);

  localparam int REM_W = upitl_pkg::SUM_W + upitl_pkg::QUOT_W - 1;

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] ds;
  logic [4:0]       cnt;
  logic             busy;
  logic             ge;

  assign ge = (rem >= ds);

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {8'b0, num, 16'b0};
      ds   <= {den, 24'b0};
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - ds;
      end
      ds   <= ds >> 1;
      quot <= {quot[upitl_pkg::QUOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(upitl_pkg::QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/upitl_back.sv
// ----------------------------------------------------------------------------
// upitl_back
// Mesh stores, triangle load sequencer and the query scan.
// ----------------------------------------------------------------------------
module upitl_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  upitl_pkg::item_t                  q_item,
  output logic                              q_pop,
  input  logic [upitl_pkg::DET_MIN_W-1:0]   det_min,
  input  logic [upitl_pkg::MARGIN_W-1:0]    margin,
  output logic                              res_valid,
  output upitl_pkg::result_t                res,
  input  logic                              res_pop
);

  localparam int VW = 2 * upitl_pkg::COORD_W;
  localparam int FW = 3 * upitl_pkg::IDX_W;

  upitl_pkg::bstate_t state;
  upitl_pkg::bstate_t state_next;
  upitl_pkg::item_t   cur;

  logic [VW-1:0] vtx_mem  [upitl_pkg::MAX_VERTICES];
  logic [FW-1:0] face_mem [upitl_pkg::MAX_FACES];
  logic [VW-1:0] blo_mem  [upitl_pkg::MAX_FACES];
  logic [VW-1:0] bhi_mem  [upitl_pkg::MAX_FACES];
  logic [VW-1:0] vtx_rd;
  logic          vtx_oor;
  logic [FW-1:0] face_rd;
  logic [VW-1:0] blo_rd;
  logic [VW-1:0] bhi_rd;

  logic [upitl_pkg::FC_W-1:0]  face_count;
  logic [upitl_pkg::FC_W-1:0]  fi;
  logic [2:0]                  step;
  logic [upitl_pkg::IDX_W-1:0] crn [3];
  logic [upitl_pkg::COORD_W-1:0] vu [3];
  logic [upitl_pkg::COORD_W-1:0] vv [3];

  logic signed [upitl_pkg::DIFF_W-1:0] e1, e2, e3, e4, dav, dpu, dpv;
  logic signed [upitl_pkg::DIFF_W-1:0] opa, opb;
  logic signed [upitl_pkg::PROD_W-1:0] prod;
  logic signed [upitl_pkg::SUM_W-1:0]  det, na, nb;
  logic [upitl_pkg::SUM_W-1:0]         det_mag;
  logic [upitl_pkg::COORD_W-1:0]       wa, wb, wc;
  logic signed [upitl_pkg::EXT_W-1:0]  wc_raw;
  logic                                hit;

  logic                          vtx_re;
  logic [upitl_pkg::IDX_W-1:0]   vtx_corner;
  logic                          div_start;
  logic [upitl_pkg::SUM_W-1:0]   div_num;
  logic                          div_done;
  logic [upitl_pkg::QUOT_W-1:0]  div_q;
  logic                          res_load;

  logic slot_vtx_ok, slot_face_ok, box_out, degen, w_all_ok, last_tri, res_free, cur_qry;
  logic signed [upitl_pkg::EXT_W-1:0] pu, pv, mm, lu, lv, hu, hv;
  logic signed [upitl_pkg::COORD_W-1:0] bx_lu, bx_lv, bx_hu, bx_hv;

  assign slot_vtx_ok  = 32'(q_item.slot) < upitl_pkg::MAX_VERTICES;
  assign slot_face_ok = 32'(q_item.slot) < upitl_pkg::MAX_FACES;
  assign cur_qry      = (cur.op == upitl_pkg::OP_QRY);
  assign res_free     = !res_valid;
  assign last_tri     = ((fi + 1'b1) == face_count);

  assign pu = upitl_pkg::sx26(cur.u);
  assign pv = upitl_pkg::sx26(cur.v);
  assign mm = signed'({{(upitl_pkg::EXT_W-upitl_pkg::MARGIN_W){1'b0}}, margin});
  assign lu = upitl_pkg::sx26(blo_rd[23:0]);
  assign lv = upitl_pkg::sx26(blo_rd[47:24]);
  assign hu = upitl_pkg::sx26(bhi_rd[23:0]);
  assign hv = upitl_pkg::sx26(bhi_rd[47:24]);
  assign box_out = (pu < lu - mm) || (pv < lv - mm) || (pu > hu + mm) || (pv > hv + mm);

  assign det_mag = det[upitl_pkg::SUM_W-1] ? (~det + 1'b1) : det;
  assign degen   = (det == '0) || (det_mag < {3'b0, det_min});

  assign wc_raw   = upitl_pkg::ONE_Q16 - upitl_pkg::sx26(wa) - upitl_pkg::sx26(wb);
  assign wc       = upitl_pkg::sat24(wc_raw);
  assign w_all_ok = upitl_pkg::w_ok(wa, margin) && upitl_pkg::w_ok(wb, margin)
                    && upitl_pkg::w_ok(wc, margin);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      upitl_pkg::B_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            upitl_pkg::OP_VTX:  state_next = upitl_pkg::B_IDLE;
            upitl_pkg::OP_FACE: state_next = slot_face_ok ? upitl_pkg::B_VRD : upitl_pkg::B_IDLE;
            upitl_pkg::OP_QRY:  state_next = (face_count == '0) ? upitl_pkg::B_QOUT
                                                                : upitl_pkg::B_QRD;
            default:            state_next = upitl_pkg::B_IDLE;
          endcase
        end
      end
      upitl_pkg::B_VRD: begin
        if (step == 3'd3) begin
          state_next = cur_qry ? upitl_pkg::B_QDIFF : upitl_pkg::B_FWR;
        end
      end
      upitl_pkg::B_FWR:   state_next = upitl_pkg::B_IDLE;
      upitl_pkg::B_QRD:   state_next = upitl_pkg::B_QBOX;
      upitl_pkg::B_QBOX: begin
        if (!box_out) begin
          state_next = upitl_pkg::B_VRD;
        end else begin
          state_next = last_tri ? upitl_pkg::B_QOUT : upitl_pkg::B_QRD;
        end
      end
      upitl_pkg::B_QDIFF: state_next = upitl_pkg::B_QMUL;
      upitl_pkg::B_QMUL: begin
        if (step == 3'd6) begin
          state_next = upitl_pkg::B_QDET;
        end
      end
      upitl_pkg::B_QDET: begin
        if (!degen) begin
          state_next = upitl_pkg::B_QDIVA;
        end else begin
          state_next = last_tri ? upitl_pkg::B_QOUT : upitl_pkg::B_QRD;
        end
      end
      upitl_pkg::B_QDIVA: begin
        if (div_done) begin
          state_next = upitl_pkg::B_QDIVB;
        end
      end
      upitl_pkg::B_QDIVB: begin
        if (div_done) begin
          state_next = upitl_pkg::B_QCHK;
        end
      end
      upitl_pkg::B_QCHK: begin
        if (w_all_ok || last_tri) begin
          state_next = upitl_pkg::B_QOUT;
        end else begin
          state_next = upitl_pkg::B_QRD;
        end
      end
      upitl_pkg::B_QOUT: begin
        if (res_free) begin
          state_next = upitl_pkg::B_IDLE;
        end
      end
      default: state_next = upitl_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop      = 1'b0;
    vtx_re     = 1'b0;
    vtx_corner = crn[0];
    div_start  = 1'b0;
    div_num    = na[upitl_pkg::SUM_W-1] ? (~na + 1'b1) : na;
    res_load   = 1'b0;
    opa        = e1;
    opb        = e4;
    unique case (state)
      upitl_pkg::B_IDLE: q_pop = q_valid;
      upitl_pkg::B_VRD: begin
        vtx_re = (step != 3'd3);
        case (step)
          3'd1:    vtx_corner = crn[1];
          3'd2:    vtx_corner = crn[2];
          default: vtx_corner = crn[0];
        endcase
      end
      upitl_pkg::B_QMUL: begin
        case (step)
          3'd1:    begin opa = e2; opb = dav; end
          3'd2:    begin opa = e1; opb = dpu; end
          3'd3:    begin opa = e2; opb = dpv; end
          3'd4:    begin opa = e3; opb = dpu; end
          3'd5:    begin opa = e4; opb = dpv; end
          default: begin opa = e1; opb = e4;  end
        endcase
      end
      upitl_pkg::B_QDET:  div_start = !degen;
      upitl_pkg::B_QDIVA: begin
        div_start = div_done;
        div_num   = nb[upitl_pkg::SUM_W-1] ? (~nb + 1'b1) : nb;
      end
      upitl_pkg::B_QOUT:  res_load = res_free;
      default: ;
    endcase
  end

  upitl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (det_mag),
    .done  (div_done),
    .quot  (div_q)
  );

  // memories
  always_ff @(posedge clk) begin
    if (state == upitl_pkg::B_IDLE && q_valid && q_item.op == upitl_pkg::OP_VTX
        && slot_vtx_ok) begin
      vtx_mem[upitl_pkg::VA_W'(q_item.slot)] <= {q_item.v, q_item.u};
    end
    if (vtx_re) begin
      vtx_rd  <= vtx_mem[upitl_pkg::VA_W'(vtx_corner)];
      vtx_oor <= !(32'(vtx_corner) < upitl_pkg::MAX_VERTICES);
    end
  end

  always_ff @(posedge clk) begin
    if (state == upitl_pkg::B_FWR) begin
      face_mem[upitl_pkg::FA_W'(cur.slot)] <= {crn[2], crn[1], crn[0]};
      blo_mem[upitl_pkg::FA_W'(cur.slot)]  <= {bx_lv, bx_lu};
      bhi_mem[upitl_pkg::FA_W'(cur.slot)]  <= {bx_hv, bx_hu};
    end
    if (state == upitl_pkg::B_QRD) begin
      face_rd <= face_mem[fi[upitl_pkg::FA_W-1:0]];
      blo_rd  <= blo_mem[fi[upitl_pkg::FA_W-1:0]];
      bhi_rd  <= bhi_mem[fi[upitl_pkg::FA_W-1:0]];
    end
  end

  // bounding box of the three loaded corners
  always_comb begin
    bx_lu = signed'(vu[0]); bx_hu = signed'(vu[0]);
    bx_lv = signed'(vv[0]); bx_hv = signed'(vv[0]);
    for (int k = 1; k < 3; k++) begin
      if (signed'(vu[k]) < bx_lu) bx_lu = signed'(vu[k]);
      if (signed'(vu[k]) > bx_hu) bx_hu = signed'(vu[k]);
      if (signed'(vv[k]) < bx_lv) bx_lv = signed'(vv[k]);
      if (signed'(vv[k]) > bx_hv) bx_hv = signed'(vv[k]);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur    <= q_item;
      crn[0] <= q_item.ca;
      crn[1] <= q_item.cb;
      crn[2] <= q_item.cc;
      fi     <= '0;
      hit    <= 1'b0;
      step   <= '0;
    end
    unique case (state)
      upitl_pkg::B_VRD: begin
        step <= step + 3'd1;
        if (step != 3'd0) begin
          vu[step[1:0] - 2'd1] <= vtx_oor ? '0 : vtx_rd[23:0];
          vv[step[1:0] - 2'd1] <= vtx_oor ? '0 : vtx_rd[47:24];
        end
      end
      upitl_pkg::B_QBOX: begin
        step <= '0;
        if (box_out) begin
          fi <= fi + 1'b1;
        end else begin
          crn[0] <= face_rd[9:0];
          crn[1] <= face_rd[19:10];
          crn[2] <= face_rd[29:20];
        end
      end
      upitl_pkg::B_QDIFF: begin
        step <= '0;
        e1   <= upitl_pkg::sx25(vv[1]) - upitl_pkg::sx25(vv[2]);
        e2   <= upitl_pkg::sx25(vu[2]) - upitl_pkg::sx25(vu[1]);
        e3   <= upitl_pkg::sx25(vv[2]) - upitl_pkg::sx25(vv[0]);
        e4   <= upitl_pkg::sx25(vu[0]) - upitl_pkg::sx25(vu[2]);
        dav  <= upitl_pkg::sx25(vv[0]) - upitl_pkg::sx25(vv[2]);
        dpu  <= upitl_pkg::sx25(cur.u) - upitl_pkg::sx25(vu[2]);
        dpv  <= upitl_pkg::sx25(cur.v) - upitl_pkg::sx25(vv[2]);
      end
      upitl_pkg::B_QMUL: begin
        step <= step + 3'd1;
        prod <= opa * opb;
        case (step)
          3'd1:    det <= upitl_pkg::SUM_W'(prod);
          3'd2:    det <= det + upitl_pkg::SUM_W'(prod);
          3'd3:    na  <= upitl_pkg::SUM_W'(prod);
          3'd4:    na  <= na + upitl_pkg::SUM_W'(prod);
          3'd5:    nb  <= upitl_pkg::SUM_W'(prod);
          3'd6:    nb  <= nb + upitl_pkg::SUM_W'(prod);
          default: ;
        endcase
      end
      upitl_pkg::B_QDET: begin
        if (degen) begin
          fi <= fi + 1'b1;
        end
      end
      upitl_pkg::B_QDIVA: begin
        if (div_done) begin
          wa <= upitl_pkg::wsat(div_q, na[upitl_pkg::SUM_W-1] ^ det[upitl_pkg::SUM_W-1]);
        end
      end
      upitl_pkg::B_QDIVB: begin
        if (div_done) begin
          wb <= upitl_pkg::wsat(div_q, nb[upitl_pkg::SUM_W-1] ^ det[upitl_pkg::SUM_W-1]);
        end
      end
      upitl_pkg::B_QCHK: begin
        if (w_all_ok) begin
          hit <= 1'b1;
        end else begin
          fi <= fi + 1'b1;
        end
      end
      default: ;
    endcase
    if (res_load) begin
      res.found <= hit;
      res.index <= hit ? upitl_pkg::IDX_W'(fi) : '0;
      res.wa    <= hit ? wa : '0;
      res.wb    <= hit ? wb : '0;
      res.wc    <= hit ? wc : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= upitl_pkg::B_IDLE;
      face_count <= '0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == upitl_pkg::B_FWR && cur.last) begin
        face_count <= upitl_pkg::FC_W'(cur.slot) + 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/uv_point_in_triangle_locator.sv
// ----------------------------------------------------------------------------
// uv_point_in_triangle_locator
// Stores a 2D triangle mesh and locates query points by barycentric weights.
// ----------------------------------------------------------------------------
// Items enter a four-deep queue and are worked off one at a time. A query
// skips the arithmetic for every triangle whose widened box misses the
// point; each one that passes it goes through the single shared multiplier
// (six products) and, unless degenerate, the bit-serial divider (once for
// each of the two weights). One query result is held until it is popped;
// loads continue meanwhile.
module uv_point_in_triangle_locator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        kind,
  input  logic [upitl_pkg::IDX_W-1:0]       slot,
  input  logic [upitl_pkg::COORD_W-1:0]     coord_u,
  input  logic [upitl_pkg::COORD_W-1:0]     coord_v,
  input  logic [upitl_pkg::IDX_W-1:0]       corner_a,
  input  logic [upitl_pkg::IDX_W-1:0]       corner_b,
  input  logic [upitl_pkg::IDX_W-1:0]       corner_c,
  input  logic                              last_face,
  output logic                              empty,
  input  logic                              pop,
  output logic                              found,
  output logic [upitl_pkg::IDX_W-1:0]       triangle_index,
  output logic [upitl_pkg::COORD_W-1:0]     weight_a,
  output logic [upitl_pkg::COORD_W-1:0]     weight_b,
  output logic [upitl_pkg::COORD_W-1:0]     weight_c,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [upitl_pkg::CFG_W-1:0]       cfg_data
);

  logic [upitl_pkg::DET_MIN_W-1:0] det_min;
  logic [upitl_pkg::MARGIN_W-1:0]  margin;
  logic                            q_valid;
  logic                            q_pop;
  upitl_pkg::item_t                q_item;
  logic                            res_valid;
  upitl_pkg::result_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_min <= upitl_pkg::DET_MIN_W'(1);
      margin  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        upitl_pkg::REG_DET_MIN: det_min <= cfg_data[upitl_pkg::DET_MIN_W-1:0];
        upitl_pkg::REG_MARGIN:  margin  <= cfg_data[upitl_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  upitl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .slot      (slot),
    .coord_u   (coord_u),
    .coord_v   (coord_v),
    .corner_a  (corner_a),
    .corner_b  (corner_b),
    .corner_c  (corner_c),
    .last_face (last_face),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  upitl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .det_min   (det_min),
    .margin    (margin),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty          = !res_valid;
  assign found          = res.found;
  assign triangle_index = res.index;
  assign weight_a       = res.wa;
  assign weight_b       = res.wb;
  assign weight_c       = res.wc;

endmodule

FILE: dv/upitl_checker.sv
// ----------------------------------------------------------------------------
// upitl_checker
// Watches the item, result and register ports of the point-in-triangle
// locator, keeps its own copy of the mesh and settings, works out the answer
// to every accepted query and compares it, field by field, with the answer
// transferred out.
// ----------------------------------------------------------------------------
module upitl_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  logic [1:0]                    kind,
  input  logic [upitl_pkg::IDX_W-1:0]   slot,
  input  logic [upitl_pkg::COORD_W-1:0] coord_u,
  input  logic [upitl_pkg::COORD_W-1:0] coord_v,
  input  logic [upitl_pkg::IDX_W-1:0]   corner_a,
  input  logic [upitl_pkg::IDX_W-1:0]   corner_b,
  input  logic [upitl_pkg::IDX_W-1:0]   corner_c,
  input  logic                          last_face,
  input  logic                          empty,
  input  logic                          pop,
  input  logic                          found,
  input  logic [upitl_pkg::IDX_W-1:0]   triangle_index,
  input  logic [upitl_pkg::COORD_W-1:0] weight_a,
  input  logic [upitl_pkg::COORD_W-1:0] weight_b,
  input  logic [upitl_pkg::COORD_W-1:0] weight_c,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [upitl_pkg::CFG_W-1:0]   cfg_data,
  output int                            errors,
  output int                            answers,
  output int                            hits,
  output int                            waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  longint  vtx_u [upitl_pkg::MAX_VERTICES];
  longint  vtx_v [upitl_pkg::MAX_VERTICES];
  int      tri_a [upitl_pkg::MAX_FACES];
  int      tri_b [upitl_pkg::MAX_FACES];
  int      tri_c [upitl_pkg::MAX_FACES];
  longint  lo_u  [upitl_pkg::MAX_FACES];
  longint  lo_v  [upitl_pkg::MAX_FACES];
  longint  hi_u  [upitl_pkg::MAX_FACES];
  longint  hi_v  [upitl_pkg::MAX_FACES];
  int      n_faces;
  longint  det_floor;
  longint  tol;
  upitl_pkg::result_t answer_q[$];

  function automatic longint sx(logic [upitl_pkg::COORD_W-1:0] x);
    return longint'(signed'(x));
  endfunction

  // num * 2^16 / den, truncated toward zero, saturated to 24 bits
  function automatic longint weight_of(longint num, longint den);
    longint n, d, q, r, fr, mag;
    n  = num < 0 ? -num : num;
    d  = den < 0 ? -den : den;
    q  = n / d;
    r  = n % d;
    fr = 0;
    if (q >= 256) begin
      mag = longint'(1) << 24;
    end else begin
      for (int k = 0; k < 16; k++) begin
        r  = r << 1;
        fr = fr << 1;
        if (r >= d) begin
          r  = r - d;
          fr = fr | 1;
        end
      end
      mag = (q << 16) | fr;
    end
    if ((num < 0) != (den < 0)) return (mag > 8388608) ? -8388608 : -mag;
    return (mag > 8388607) ? 8388607 : mag;
  endfunction

  function automatic bit in_tol(longint w);
    return (w >= -tol) && (w <= 65536 + tol);
  endfunction

  function automatic upitl_pkg::result_t locate(longint pu, longint pv);
    upitl_pkg::result_t r;
    longint  au, av, bu, bv, cu, cv, det, mag, wa, wb, wc;
    r = '0;
    for (int i = 0; i < n_faces; i++) begin
      if (pu < lo_u[i] - tol || pv < lo_v[i] - tol ||
          pu > hi_u[i] + tol || pv > hi_v[i] + tol) continue;
      au  = vtx_u[tri_a[i]]; av = vtx_v[tri_a[i]];
      bu  = vtx_u[tri_b[i]]; bv = vtx_v[tri_b[i]];
      cu  = vtx_u[tri_c[i]]; cv = vtx_v[tri_c[i]];
      det = (bv - cv) * (au - cu) + (cu - bu) * (av - cv);
      mag = det < 0 ? -det : det;
      if (det == 0 || mag < det_floor) continue;
      wa = weight_of((bv - cv) * (pu - cu) + (cu - bu) * (pv - cv), det);
      wb = weight_of((cv - av) * (pu - cu) + (au - cu) * (pv - cv), det);
      wc = 65536 - wa - wb;
      if (wc > 8388607) wc = 8388607;
      if (wc < -8388608) wc = -8388608;
      if (in_tol(wa) && in_tol(wb) && in_tol(wc)) begin
        r.found = 1'b1;
        r.index = i[upitl_pkg::IDX_W-1:0];
        r.wa    = wa[upitl_pkg::COORD_W-1:0];
        r.wb    = wb[upitl_pkg::COORD_W-1:0];
        r.wc    = wc[upitl_pkg::COORD_W-1:0];
        break;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    upitl_pkg::result_t want;
    longint  au, av, bu, bv, cu, cv;
    if (rst) begin
      n_faces   = 0;
      det_floor = 1;
      tol       = 0;
      answer_q.delete();
      errors    = 0;
      answers   <= 0;
      hits      <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == upitl_pkg::REG_DET_MIN) det_floor = longint'(cfg_data);
        else tol = longint'(cfg_data[upitl_pkg::MARGIN_W-1:0]);
      end
      if (pop && !empty) begin
        if (answer_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transfer, found=%0d index=%0d",
                   $time, found, triangle_index);
        end else begin
          want = answer_q.pop_front();
          check_field("found", want.found, found);
          check_field("triangle_index", want.index, triangle_index);
          check_field("weight_a", sx(want.wa), sx(weight_a));
          check_field("weight_b", sx(want.wb), sx(weight_b));
          check_field("weight_c", sx(want.wc), sx(weight_c));
          answers <= answers + 1;
          if (want.found) hits <= hits + 1;
        end
      end
      if (push && !full) begin
        case (kind)
          upitl_pkg::KIND_VTX: begin
            vtx_u[slot] = sx(coord_u);
            vtx_v[slot] = sx(coord_v);
          end
          upitl_pkg::KIND_FACE: begin
            au = vtx_u[corner_a]; av = vtx_v[corner_a];
            bu = vtx_u[corner_b]; bv = vtx_v[corner_b];
            cu = vtx_u[corner_c]; cv = vtx_v[corner_c];
            tri_a[slot] = corner_a;
            tri_b[slot] = corner_b;
            tri_c[slot] = corner_c;
            lo_u[slot]  = au < bu ? (au < cu ? au : cu) : (bu < cu ? bu : cu);
            hi_u[slot]  = au > bu ? (au > cu ? au : cu) : (bu > cu ? bu : cu);
            lo_v[slot]  = av < bv ? (av < cv ? av : cv) : (bv < cv ? bv : cv);
            hi_v[slot]  = av > bv ? (av > cv ? av : cv) : (bv > cv ? bv : cv);
            if (last_face) n_faces = int'(slot) + 1;
          end
          upitl_pkg::KIND_QRY: answer_q.push_back(locate(sx(coord_u), sx(coord_v)));
          default: ;
        endcase
      end
    end
    waiting <= answer_q.size();
  end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the point-in-triangle locator with a short directed mesh covering
// extreme coordinates, degenerate and collinear triangles, stale boxes and
// ignored items, then random meshes with queries mostly aimed inside their
// triangles, under six register settings and three idling patterns. A
// separate checker predicts and compares every answer.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int         STALL_LIMIT = 200000;
  localparam longint     CMAX = 8388607;
  localparam longint     CMIN = -8388608;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  logic [1:0]                    kind = '0;
  logic [upitl_pkg::IDX_W-1:0]   slot = '0;
  logic [upitl_pkg::COORD_W-1:0] coord_u = '0;
  logic [upitl_pkg::COORD_W-1:0] coord_v = '0;
  logic [upitl_pkg::IDX_W-1:0]   corner_a = '0;
  logic [upitl_pkg::IDX_W-1:0]   corner_b = '0;
  logic [upitl_pkg::IDX_W-1:0]   corner_c = '0;
  logic                          last_face = 1'b0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic                          found;
  logic [upitl_pkg::IDX_W-1:0]   triangle_index;
  logic [upitl_pkg::COORD_W-1:0] weight_a, weight_b, weight_c;
  logic                          cfg_write = 1'b0;
  logic                          cfg_index = 1'b0;
  logic [upitl_pkg::CFG_W-1:0]   cfg_data = '0;
  int                            errors, answers, hits, waiting;
  int                            send_idle = 0;
  int                            pop_stall = 0;
  int                            sent = 0;
  int                            quiet = 0;

  // generator's view of the mesh
  longint mesh_u [upitl_pkg::MAX_VERTICES];
  longint mesh_v [upitl_pkg::MAX_VERTICES];
  int     face_a [upitl_pkg::MAX_FACES];
  int     face_b [upitl_pkg::MAX_FACES];
  int     face_c [upitl_pkg::MAX_FACES];
  int     scene_vtx[$];
  int     scene_faces;

  uv_point_in_triangle_locator dut (.*);

  upitl_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) pop = ($urandom_range(99) >= pop_stall);

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("uv_point_in_triangle_locator verification failed");
      $finish;
    end
  end

  function automatic longint clampc(longint x);
    return x > CMAX ? CMAX : (x < CMIN ? CMIN : x);
  endfunction

  task automatic send(logic [1:0] k, int s, longint u, longint v,
                      int a, int b, int c, bit l);
    while ($urandom_range(99) < send_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    push      = 1'b1;
    kind      = k;
    slot      = s[upitl_pkg::IDX_W-1:0];
    coord_u   = u[upitl_pkg::COORD_W-1:0];
    coord_v   = v[upitl_pkg::COORD_W-1:0];
    corner_a  = a[upitl_pkg::IDX_W-1:0];
    corner_b  = b[upitl_pkg::IDX_W-1:0];
    corner_c  = c[upitl_pkg::IDX_W-1:0];
    last_face = l;
    if (k == upitl_pkg::KIND_VTX) begin
      mesh_u[s] = u;
      mesh_v[s] = v;
    end else if (k == upitl_pkg::KIND_FACE) begin
      face_a[s] = a;
      face_b[s] = b;
      face_c[s] = c;
    end
    // full only moves at the rising edge, so it is stable here
    while (full) @(negedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic set_reg(logic idx, longint value);
    push = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value[upitl_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // a point inside face f, by random integer weights over 256
  task automatic aim(int f, output longint pu, output longint pv);
    int w1, w2, w3;
    w1 = $urandom_range(256);
    w2 = $urandom_range(256 - w1);
    w3 = 256 - w1 - w2;
    pu = (mesh_u[face_a[f]] * w1 + mesh_u[face_b[f]] * w2 + mesh_u[face_c[f]] * w3) / 256;
    pv = (mesh_v[face_a[f]] * w1 + mesh_v[face_b[f]] * w2 + mesh_v[face_c[f]] * w3) / 256;
  endtask

  task automatic random_scene();
    int     nv, r, s;
    longint cu, cv, span, pu, pv;
    scene_vtx.delete();
    r    = $urandom_range(99);
    span = r < 70 ? longint'($urandom_range(1 << 17, 1 << 14)) :
           r < 90 ? longint'($urandom_range(1 << 20)) + 1 : CMAX;
    cu   = longint'($urandom_range(1 << 23)) - (1 << 22);
    cv   = longint'($urandom_range(1 << 23)) - (1 << 22);
    nv   = $urandom_range(6, 3);
    scene_faces = ($urandom_range(19) == 0) ? $urandom_range(30, 16) : $urandom_range(6, 1);
    for (int i = 0; i < nv; i++) begin
      s = $urandom_range(upitl_pkg::MAX_VERTICES - 1);
      scene_vtx.push_back(s);
      send(upitl_pkg::KIND_VTX, s,
           clampc(cu + longint'($urandom_range(2 * span)) - span),
           clampc(cv + longint'($urandom_range(2 * span)) - span), 0, 0, 0, 0);
    end
    for (int f = 0; f < scene_faces; f++) begin
      send(upitl_pkg::KIND_FACE, f, $urandom, $urandom,
           scene_vtx[$urandom_range(nv - 1)], scene_vtx[$urandom_range(nv - 1)],
           scene_vtx[$urandom_range(nv - 1)], f == scene_faces - 1);
    end
    if ($urandom_range(9) == 0) begin
      s = $urandom_range(upitl_pkg::MAX_FACES - 1, scene_faces);
      send(upitl_pkg::KIND_FACE, s, 0, 0, scene_vtx[0], scene_vtx[1], scene_vtx[2], 0);
    end
    repeat ($urandom_range(10, 4)) begin
      r = $urandom_range(99);
      if (r < 70) begin
        aim($urandom_range(scene_faces - 1), pu, pv);
        pu = clampc(pu + longint'($urandom_range(64)) - 32);
        pv = clampc(pv + longint'($urandom_range(64)) - 32);
      end else if (r < 90) begin
        pu = clampc(cu + longint'($urandom_range(2 * span)) - span);
        pv = clampc(cv + longint'($urandom_range(2 * span)) - span);
      end else begin
        pu = longint'(signed'(24'($urandom)));
        pv = longint'(signed'(24'($urandom)));
      end
      send(upitl_pkg::KIND_QRY, $urandom, pu, pv, $urandom, $urandom, $urandom, $urandom);
      r = $urandom_range(99);
      if (r < 4) begin
        s = scene_vtx[$urandom_range(nv - 1)];
        send(upitl_pkg::KIND_VTX, s,
             clampc(mesh_u[s] + longint'($urandom_range(2 * span)) - span),
             mesh_v[s], 0, 0, 0, 0);
      end else if (r < 7) begin
        send(KIND_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom);
      end
    end
  endtask

  initial begin
    longint det_set [6];
    longint tol_set [6];
    det_set = '{1, 0, 48'hFFFF_FFFF_FFFF, longint'($urandom_range(1 << 30)) << 4,
                1, 0};
    tol_set = '{0, 65535, longint'($urandom_range(65535)), 0,
                longint'($urandom_range(2000)), 0};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_idle = 31;
    pop_stall = 60;

    // directed
    send(upitl_pkg::KIND_QRY, 0, 0, 0, 0, 0, 0, 0);
    send(upitl_pkg::KIND_VTX, 0, 0, 0, 0, 0, 0, 0);
    send(upitl_pkg::KIND_VTX, 1, 65536, 0, 0, 0, 0, 0);
    send(upitl_pkg::KIND_VTX, 2, 0, 65536, 0, 0, 0, 0);
    send(upitl_pkg::KIND_VTX, 3, 131072, 0, 0, 0, 0, 0);
    send(upitl_pkg::KIND_VTX, 1023, CMAX, CMAX, 0, 0, 0, 0);
    send(upitl_pkg::KIND_VTX, 512, CMIN, CMIN, 0, 0, 0, 0);
    send(upitl_pkg::KIND_FACE, 0, 0, 0, 0, 1, 2, 0);
    send(upitl_pkg::KIND_FACE, 1, 0, 0, 0, 1, 3, 0);
    send(upitl_pkg::KIND_FACE, 2, 0, 0, 1023, 512, 0, 1);
    send(upitl_pkg::KIND_FACE, 1023, 0, 0, 1023, 512, 2, 0);
    send(upitl_pkg::KIND_QRY, 1023, 16384, 16384, 1023, 1023, 1023, 1);
    send(upitl_pkg::KIND_QRY, 0, 0, 0, 0, 0, 0, 0);
    send(upitl_pkg::KIND_QRY, 0, 65536, 65536, 0, 0, 0, 0);
    send(upitl_pkg::KIND_QRY, 0, CMIN, CMIN, 0, 0, 0, 0);
    send(upitl_pkg::KIND_QRY, 0, CMAX, CMAX, 0, 0, 0, 0);
    send(KIND_SPARE, 1023, CMAX, CMIN, 1023, 1023, 1023, 1);
    send(upitl_pkg::KIND_VTX, 2, 0, 131072, 0, 0, 0, 0);
    send(upitl_pkg::KIND_QRY, 0, 16384, 60000, 0, 0, 0, 0);
    send(upitl_pkg::KIND_QRY, 0, 65536, 0, 0, 0, 0, 0);
    set_reg(upitl_pkg::REG_MARGIN, 65535);
    send(upitl_pkg::KIND_QRY, 0, 70000, -1000, 0, 0, 0, 0);
    set_reg(upitl_pkg::REG_DET_MIN, 48'hFFFF_FFFF_FFFF);
    send(upitl_pkg::KIND_QRY, 0, 16384, 16384, 0, 0, 0, 0);

    // random meshes, six register settings over three idling patterns
    for (int seg = 0; seg < 6; seg++) begin
      send_idle = seg < 2 ? 31 : (seg < 4 ? 60 : 0);
      pop_stall = seg < 2 ? 60 : (seg < 4 ? 31 : 0);
      set_reg(upitl_pkg::REG_DET_MIN, det_set[seg]);
      set_reg(upitl_pkg::REG_MARGIN, tol_set[seg]);
      while (sent < (seg + 1) * 88) random_scene();
    end

    push = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("sent %0d items; %0d query answers checked, %0d of them hits",
             sent, answers, hits);
    $display("settings: six det_min/margin pairs incl. both extremes of each register");
    if (errors == 0) begin
      $display("uv_point_in_triangle_locator verification clean");
    end else begin
      $display("uv_point_in_triangle_locator verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/upitl_pkg.sv
rtl/core/upitl_front.sv
rtl/core/upitl_div.sv
rtl/core/upitl_back.sv
rtl/core/uv_point_in_triangle_locator.sv
dv/upitl_checker.sv
dv/tb.sv
